### rtl/rtat_pkg.sv
package rtat_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 64;

  // operation codes of the func field
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // input transaction
  typedef struct packed {
    logic              func;
    logic [7:0]        entry_index;
    logic [ADDR_W-1:0] range_source_start;
    logic [ADDR_W-1:0] range_length;
    logic [ADDR_W-1:0] range_dest_start;
    logic [ADDR_W-1:0] lookup_address;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [ADDR_W-1:0] translated_address;
    logic              found;
  } out_t;

  // one table entry as stored: start, wrapped end, and dest minus start
  typedef struct packed {
    logic [ADDR_W-1:0] src_start;
    logic [ADDR_W-1:0] src_end;
    logic [ADDR_W-1:0] delta;
  } ent_t;

  // classified command between front and back; a lookup carries its
  // address in ent.src_start
  typedef struct packed {
    logic             lookup;
    logic [IDX_W-1:0] index;
    ent_t             ent;
  } cmd_t;

endpackage

### rtl/rtat_front.sv
module rtat_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rtat_pkg::in_t     in_data,
  output logic              cmd_valid,
  output rtat_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  rtat_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  rtat_pkg::cmd_t cls;
  logic           push;

  // classify the transaction and precompute range end and translation delta
  always_comb begin
    cls.lookup = (in_data.func == rtat_pkg::FUNC_LOOKUP);
    cls.index  = in_data.entry_index[rtat_pkg::IDX_W-1:0];
    if (in_data.func == rtat_pkg::FUNC_LOOKUP) begin
      cls.ent.src_start = in_data.lookup_address;
      cls.ent.src_end   = '0;
      cls.ent.delta     = '0;
    end else begin
      cls.ent.src_start = in_data.range_source_start;
      cls.ent.src_end   = in_data.range_source_start + in_data.range_length;
      cls.ent.delta     = in_data.range_dest_start - in_data.range_source_start;
    end
  end

  assign in_ready  = (count != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // two-entry queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !cmd_pop) begin
        count <= count + 2'd1;
      end else if (cmd_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/rtat_back.sv
module rtat_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  rtat_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       cfg_write_en,
  input  logic [rtat_pkg::CNT_W-1:0] cfg_write_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rtat_pkg::out_t             out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FINISH
  } state_t;

  state_t                      state;
  logic [rtat_pkg::CNT_W-1:0]  entry_count;
  logic [rtat_pkg::CNT_W-1:0]  cnt_sat;
  logic [rtat_pkg::CNT_W-1:0]  lo;
  logic [rtat_pkg::CNT_W-1:0]  hb;
  logic [rtat_pkg::IDX_W-1:0]  mid;
  logic [rtat_pkg::ADDR_W-1:0] addr;
  logic [rtat_pkg::ADDR_W-1:0] res_addr;
  logic                        res_found;

  rtat_pkg::ent_t              mem [rtat_pkg::TABLE_DEPTH];
  rtat_pkg::ent_t              rd_q;
  logic                        mem_we;
  logic                        rd_en;
  logic [rtat_pkg::IDX_W-1:0]  rd_addr;

  logic [rtat_pkg::CNT_W-1:0]  mid_w;
  logic [rtat_pkg::CNT_W-1:0]  first_mid;
  logic                        hit;
  logic                        ge_end;
  logic [rtat_pkg::CNT_W-1:0]  lo_next;
  logic [rtat_pkg::CNT_W-1:0]  hb_next;
  logic [rtat_pkg::CNT_W-1:0]  mid_next;
  logic                        out_free;

  // search bound, saturated to the table depth
  always_comb begin
    if (entry_count > rtat_pkg::CNT_W'(rtat_pkg::TABLE_DEPTH)) begin
      cnt_sat = rtat_pkg::CNT_W'(rtat_pkg::TABLE_DEPTH);
    end else begin
      cnt_sat = entry_count;
    end
  end

  // compare against the entry read for the current probe, next bounds
  always_comb begin
    mid_w     = {1'b0, mid};
    first_mid = (cnt_sat - rtat_pkg::CNT_W'(1)) >> 1;
    hit       = (addr >= rd_q.src_start) && (addr < rd_q.src_end);
    ge_end    = (addr >= rd_q.src_end);
    if (ge_end) begin
      lo_next = mid_w + rtat_pkg::CNT_W'(1);
      hb_next = hb;
    end else begin
      lo_next = lo;
      hb_next = mid_w;
    end
    mid_next = lo_next + ((hb_next - lo_next - rtat_pkg::CNT_W'(1)) >> 1);
  end

  // queue pop, table write and read port control
  always_comb begin
    cmd_pop  = (state == ST_IDLE) && cmd_valid;
    mem_we   = cmd_pop && !cmd.lookup;
    out_free = !out_valid || out_ready;
    rd_en    = 1'b0;
    rd_addr  = first_mid[rtat_pkg::IDX_W-1:0];
    if (cmd_pop && cmd.lookup && (cnt_sat != '0)) begin
      rd_en = 1'b1;
    end else if ((state == ST_LOOK) && !hit && (lo_next < hb_next)) begin
      rd_en   = 1'b1;
      rd_addr = mid_next[rtat_pkg::IDX_W-1:0];
    end
  end

  // range table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd.index] <= cmd.ent;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entry count register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_write_en) begin
      entry_count <= cfg_write_data;
    end
  end

  // search sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the finish state reloads the output itself
      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop && cmd.lookup) begin
            addr <= cmd.ent.src_start;
            if (cnt_sat == '0) begin
              res_addr  <= '0;
              res_found <= 1'b0;
              state     <= ST_FINISH;
            end else begin
              lo    <= '0;
              hb    <= cnt_sat;
              mid   <= rd_addr;
              state <= ST_LOOK;
            end
          end
        end
        ST_LOOK: begin
          if (hit) begin
            res_addr  <= addr + rd_q.delta;
            res_found <= 1'b1;
            state     <= ST_FINISH;
          end else if (lo_next < hb_next) begin
            lo  <= lo_next;
            hb  <= hb_next;
            mid <= rd_addr;
          end else begin
            res_addr  <= '0;
            res_found <= 1'b0;
            state     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid                   <= 1'b1;
            out_data.translated_address <= res_addr;
            out_data.found              <= res_found;
            state                       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a probe always lies inside a non-empty window
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> ((lo < hb) && (mid_w >= lo) && (mid_w < hb)))
    else $error("search window empty or probe outside it");

  // the upper bound never passes the table depth
  a_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |-> (hb <= rtat_pkg::CNT_W'(rtat_pkg::TABLE_DEPTH)))
    else $error("search bound beyond table depth");

  // a result appears only out of the finish state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result loaded outside finish state");

  // a finished lookup is never dropped while the output is held
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FINISH) && out_valid && !out_ready) |=> (state == ST_FINISH))
    else $error("finished lookup left while output stalled");

  // a probe read follows every window update
  a_probe_read: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LOOK) && !hit && (lo_next < hb_next)) |-> rd_en)
    else $error("search continued without a table read");
`endif

endmodule

### rtl/range_table_address_translate_top.sv
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------
// input    | in_valid / in_ready   | in_data  (rtat_pkg::in_t)
// output   | out_valid / out_ready | out_data (rtat_pkg::out_t)
// config   | cfg_write_en          | cfg_write_data (entry count)
//
// a table write leaves the two-entry queue when the sequencer is idle and is
// stored at that same edge; a lookup is issued from the queue head, then
// probes the table (at most ceil(log2(n+1)) probes for n searched entries,
// nine for 256) and is loaded into the output register once that is free
// rst is synchronous and clears queue, sequencer, output valid and entry count,
// not the table; while the output stalls the queue fills up to two entries
module range_table_address_translate_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rtat_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rtat_pkg::out_t             out_data,
  input  logic                       cfg_write_en,
  input  logic [rtat_pkg::CNT_W-1:0] cfg_write_data
);

  logic           cmd_valid;
  logic           cmd_pop;
  rtat_pkg::cmd_t cmd;

  // accept, classify and queue
  rtat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // table store and binary search
  rtat_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule
